[hw/rtl/eatt_pkg.sv]
// Package: shared types and constants for the eased ramp timer table.
package eatt_pkg;

	localparam logic [1:0] CMD_PLAY       = 2'd0;
	localparam logic [1:0] CMD_CANCEL     = 2'd1;
	localparam logic [1:0] CMD_CANCEL_ALL = 2'd2;
	localparam logic [1:0] CMD_TICK       = 2'd3;

	localparam logic [1:0] KIND_UPDATE = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_ACK    = 2'd2;

	localparam logic [1:0] CURVE_OUT   = 2'd1;
	localparam logic [1:0] CURVE_INOUT = 2'd2;

	localparam logic [16:0] Q_ONE = 17'd65536;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ZD_UPD,
		ST_ZD_DONE,
		ST_SCAN,
		ST_DIV,
		ST_EASE1,
		ST_EASE2,
		ST_DONE_SCAN,
		ST_COMPACT,
		ST_ACK,
		ST_EMIT
	} eatt_state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load_req;
		logic       store_play;
		logic       clr_idx;
		logic       inc_idx;
		logic       div_start;
		logic       ease1;
		logic       ease2;
		logic       mark_fin;
		logic       cancel_one;
		logic       cancel_all;
		logic       compact_step;
		logic       emit;
		logic [1:0] kind;
		logic [1:0] emit_src;
	} eatt_cmd_t;

	localparam logic [1:0] SRC_ENTRY = 2'd0;
	localparam logic [1:0] SRC_ZERO  = 2'd1;
	localparam logic [1:0] SRC_ONE   = 2'd2;
	localparam logic [1:0] SRC_ACK   = 2'd3;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       dur_zero;
		logic       idx_end;
		logic       cur_valid;
		logic       waiting;
		logic       need_div;
		logic       div_busy;
		logic       cur_fin;
		logic       match;
		logic       compact_done;
		logic       out_busy;
	} eatt_stat_t;

endpackage

[hw/rtl/eatt_divider.sv]
// Restoring divider: (run << 16) / duration, one quotient bit per cycle.
module eatt_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] run,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [16:0] quotient
);
	logic [16:0] rem_q;
	logic [31:0] num_q;
	logic [15:0] den_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;

	assign trial = {rem_q[15:0], num_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 5'd0;
		end else if (busy) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= '0;
			num_q    <= {run, 16'd0};
			den_q    <= divisor;
			quotient <= '0;
		end else if (busy) begin
			num_q <= {num_q[30:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q    <= trial - {1'b0, den_q};
				quotient <= {quotient[15:0], 1'b1};
			end else begin
				rem_q    <= trial;
				quotient <= {quotient[15:0], 1'b0};
			end
		end
	end
endmodule

[hw/rtl/eatt_datapath.sv]
// Datapath: entry table, progress and easing arithmetic, output register.
module eatt_datapath #(
	parameter int MAX_ANIMATIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  eatt_pkg::eatt_cmd_t cmd,
	output eatt_pkg::eatt_stat_t stat,
	input  logic [1:0]          command,
	input  logic [31:0]         time_ms,
	input  logic [15:0]         duration_ms,
	input  logic [15:0]         delay_ms,
	input  logic [1:0]          curve,
	input  logic [15:0]         anim_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          result_kind,
	output logic [15:0]         out_id,
	output logic [16:0]         eased_value,
	output logic                completed_normally,
	output logic                any_active,
	output logic                table_full,
	output logic                last
);
	import eatt_pkg::*;

	localparam int IW = $clog2(MAX_ANIMATIONS + 1);
	localparam int AW = (MAX_ANIMATIONS > 1) ? $clog2(MAX_ANIMATIONS) : 1;

	logic [MAX_ANIMATIONS-1:0] valid_q, fin_q;
	logic [15:0] id_q    [MAX_ANIMATIONS];
	logic [31:0] start_q [MAX_ANIMATIONS];
	logic [15:0] delay_q [MAX_ANIMATIONS];
	logic [15:0] dur_q   [MAX_ANIMATIONS];
	logic [1:0]  curve_q [MAX_ANIMATIONS];
	logic [15:0] next_id_q;

	logic [1:0]  r_cmd_q;
	logic [31:0] r_time_q;
	logic [15:0] r_dur_q, r_dly_q, r_aid_q;
	logic [1:0]  r_curve_q;
	logic [IW-1:0] idx_q, wr_q, cnt_q;
	logic        full_q, hit_q;
	logic [16:0] p_q;
	logic [33:0] sq_q;

	logic [AW-1:0] ia;
	logic [31:0]   el;
	logic [31:0]   run;
	logic          div_busy, need_div;
	logic [16:0]   quot;
	logic [16:0]   ease_in;
	logic [16:0]   ease_res;
	logic [IW-1:0] count;

	// next result fields
	logic [15:0]   emit_id;
	logic [16:0]   emit_val;
	logic          emit_norm, emit_act, emit_full, emit_last;

	assign ia  = idx_q[AW-1:0];
	assign el  = r_time_q - start_q[ia];
	assign run = el - {16'd0, delay_q[ia]};
	assign need_div = run < {16'd0, dur_q[ia]};

	always_comb begin
		count = '0;
		for (int i = 0; i < MAX_ANIMATIONS; i++)
			if (valid_q[i])
				count = IW'(i + 1);
	end

	eatt_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.run(run[15:0]), .divisor(dur_q[ia]),
		.busy(div_busy), .quotient(quot)
	);

	// ease operand: the value that the ease2 step squares
	always_comb begin
		ease_in = p_q;
		if (curve_q[ia] == CURVE_OUT)
			ease_in = Q_ONE - p_q;
		else if (curve_q[ia] == CURVE_INOUT && p_q >= 17'd32768)
			ease_in = 17'((18'd131072 - {p_q, 1'b0}));
	end

	always_comb begin
		ease_res = p_q;
		if (curve_q[ia] == CURVE_OUT)
			ease_res = Q_ONE - 17'((sq_q + 34'd32768) >> 16);
		else if (curve_q[ia] == CURVE_INOUT) begin
			if (p_q < 17'd32768)
				ease_res = 17'((sq_q + 34'd16384) >> 15);
			else
				ease_res = Q_ONE - 17'((sq_q + 34'd65536) >> 17);
		end
	end

	always_comb begin
		stat.cmd          = r_cmd_q;
		stat.dur_zero     = (r_dur_q == 16'd0);
		stat.idx_end      = (idx_q >= cnt_q);
		stat.cur_valid    = (idx_q < IW'(MAX_ANIMATIONS)) && valid_q[ia];
		stat.waiting      = el < {16'd0, delay_q[ia]};
		stat.need_div     = need_div;
		stat.div_busy     = div_busy;
		stat.cur_fin      = fin_q[ia];
		stat.match        = (r_aid_q != 16'd0) && (id_q[ia] == r_aid_q);
		stat.compact_done = (idx_q >= cnt_q);
		stat.out_busy     = out_valid && !out_ready;
	end

	// result field select
	always_comb begin
		emit_id   = '0;
		emit_val  = '0;
		emit_norm = 1'b0;
		emit_act  = 1'b0;
		emit_full = 1'b0;
		emit_last = 1'b0;
		unique case (cmd.emit_src)
			SRC_ENTRY: begin
				emit_id = (r_cmd_q == CMD_CANCEL) ? r_aid_q : id_q[ia];
				if (cmd.kind == KIND_UPDATE)
					emit_val = ease_res;
				// only a tick completion ran to its end
				emit_norm = (cmd.kind == KIND_DONE) && (r_cmd_q == CMD_TICK);
			end
			SRC_ZERO: begin
				emit_norm = 1'b1;
			end
			SRC_ONE: begin
				emit_val = Q_ONE;
			end
			SRC_ACK: begin
				emit_last = 1'b1;
				if (r_cmd_q == CMD_PLAY) begin
					emit_full = full_q;
					if (hit_q)
						emit_id = id_q[cnt_q[AW-1:0]];
				end
				if (r_cmd_q == CMD_TICK)
					emit_act = (wr_q != '0);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			fin_q     <= '0;
			next_id_q <= 16'd1;
			out_valid <= 1'b0;
			idx_q     <= '0;
			wr_q      <= '0;
			cnt_q     <= '0;
			full_q    <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (cmd.load_req) begin
				cnt_q  <= count;
				fin_q  <= '0;
				full_q <= 1'b0;
				hit_q  <= 1'b0;
				idx_q  <= '0;
				wr_q   <= '0;
			end
			if (cmd.clr_idx) begin
				idx_q <= '0;
				wr_q  <= '0;
			end
			if (cmd.inc_idx)
				idx_q <= idx_q + IW'(1);
			if (cmd.store_play) begin
				if (cnt_q >= IW'(MAX_ANIMATIONS))
					full_q <= 1'b1;
				else begin
					valid_q[cnt_q[AW-1:0]] <= 1'b1;
					next_id_q <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
					hit_q <= 1'b1;
				end
			end
			if (cmd.mark_fin)
				fin_q[ia] <= 1'b1;
			if (cmd.cancel_one) begin
				// entry idx_q drops out; mark it and compact
				fin_q[ia] <= 1'b1;
				hit_q     <= 1'b1;
			end
			if (cmd.cancel_all)
				valid_q <= '0;
			if (cmd.compact_step) begin
				if (!fin_q[ia])
					wr_q <= wr_q + IW'(1);
				else
					valid_q[cnt_q[AW-1:0] - 1'b1 - AW'(idx_q - wr_q)] <= 1'b0;
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			r_cmd_q   <= command;
			r_time_q  <= time_ms;
			r_dur_q   <= duration_ms;
			r_dly_q   <= delay_ms;
			r_curve_q <= curve;
			r_aid_q   <= anim_id;
		end
		if (cmd.store_play && cnt_q < IW'(MAX_ANIMATIONS)) begin
			id_q[cnt_q[AW-1:0]]    <= next_id_q;
			start_q[cnt_q[AW-1:0]] <= r_time_q;
			delay_q[cnt_q[AW-1:0]] <= r_dly_q;
			dur_q[cnt_q[AW-1:0]]   <= r_dur_q;
			curve_q[cnt_q[AW-1:0]] <= r_curve_q;
		end
		if (cmd.compact_step && !fin_q[ia] && wr_q != idx_q) begin
			id_q[wr_q[AW-1:0]]    <= id_q[ia];
			start_q[wr_q[AW-1:0]] <= start_q[ia];
			delay_q[wr_q[AW-1:0]] <= delay_q[ia];
			dur_q[wr_q[AW-1:0]]   <= dur_q[ia];
			curve_q[wr_q[AW-1:0]] <= curve_q[ia];
		end
		if (cmd.ease1) begin
			if (!need_div || dur_q[ia] == 16'd0)
				p_q <= Q_ONE;
			else
				p_q <= quot;
		end
		if (cmd.ease2)
			sq_q <= ease_in * ease_in;
		if (cmd.emit) begin
			result_kind        <= cmd.kind;
			out_id             <= emit_id;
			eased_value        <= emit_val;
			completed_normally <= emit_norm;
			any_active         <= emit_act;
			table_full         <= emit_full;
			last               <= emit_last;
		end
	end
endmodule

[hw/rtl/eatt_ctrl.sv]
// Controller: sequences play, cancel, cancel-all and tick over the table.
module eatt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 ready,
	input  eatt_pkg::eatt_stat_t stat,
	output eatt_pkg::eatt_cmd_t  cmd
);
	import eatt_pkg::*;

	eatt_state_t state_q, state_d, ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// ST_EMIT waits for the output register to free, then returns to ret_q
	always_comb begin
		cmd     = '0;
		ready   = 1'b0;
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				ready = !stat.out_busy;
				if (valid && ready) begin
					cmd.load_req = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.cmd)
					CMD_PLAY: begin
						if (stat.dur_zero) state_d = ST_ZD_UPD;
						else begin
							cmd.store_play = 1'b1;
							state_d = ST_ACK;
						end
					end
					CMD_TICK: state_d = ST_SCAN;
					default:  state_d = ST_SCAN;
				endcase
			end
			ST_ZD_UPD: if (!stat.out_busy) begin
				cmd.emit = 1'b1; cmd.kind = KIND_UPDATE; cmd.emit_src = SRC_ONE;
				state_d = ST_ZD_DONE;
			end
			ST_ZD_DONE: if (!stat.out_busy) begin
				cmd.emit = 1'b1; cmd.kind = KIND_DONE; cmd.emit_src = SRC_ZERO;
				state_d = ST_ACK;
			end
			ST_SCAN: begin
				if (stat.idx_end) begin
					cmd.clr_idx = 1'b1;
					state_d = (stat.cmd == CMD_TICK) ? ST_DONE_SCAN :
						(stat.cmd == CMD_CANCEL_ALL) ? ST_ACK : ST_COMPACT;
					if (stat.cmd == CMD_CANCEL_ALL) cmd.cancel_all = 1'b1;
				end else if (stat.cmd == CMD_CANCEL_ALL) begin
					if (!stat.out_busy) begin
						cmd.emit = 1'b1; cmd.kind = KIND_DONE; cmd.emit_src = SRC_ENTRY;
						cmd.inc_idx = 1'b1;
					end
				end else if (stat.cmd == CMD_CANCEL) begin
					if (stat.match) begin
						if (!stat.out_busy) begin
							cmd.cancel_one = 1'b1;
							cmd.emit = 1'b1; cmd.kind = KIND_DONE; cmd.emit_src = SRC_ENTRY;
							cmd.clr_idx = 1'b1;
							state_d = ST_COMPACT;
						end
					end else cmd.inc_idx = 1'b1;
				end else begin
					if (stat.waiting) cmd.inc_idx = 1'b1;
					else if (stat.need_div) begin
						cmd.div_start = 1'b1;
						state_d = ST_DIV;
					end else state_d = ST_EASE1;
				end
			end
			ST_DIV: if (!stat.div_busy) state_d = ST_EASE1;
			ST_EASE1: begin
				cmd.ease1 = 1'b1;
				state_d = ST_EASE2;
			end
			ST_EASE2: begin
				cmd.ease2 = 1'b1;
				state_d = ST_EMIT;
				ret_d = ST_SCAN;
			end
			ST_EMIT: if (!stat.out_busy) begin
				cmd.emit = 1'b1; cmd.kind = KIND_UPDATE; cmd.emit_src = SRC_ENTRY;
				cmd.inc_idx = 1'b1;
				state_d = ret_q;
			end
			ST_DONE_SCAN: begin
				if (stat.idx_end) begin
					cmd.clr_idx = 1'b1;
					state_d = ST_COMPACT;
				end else if (stat.cur_fin) begin
					if (!stat.out_busy) begin
						cmd.emit = 1'b1; cmd.kind = KIND_DONE; cmd.emit_src = SRC_ENTRY;
						cmd.inc_idx = 1'b1;
					end
				end else cmd.inc_idx = 1'b1;
			end
			ST_COMPACT: begin
				if (stat.compact_done) state_d = ST_ACK;
				else cmd.compact_step = 1'b1;
			end
			ST_ACK: if (!stat.out_busy) begin
				cmd.emit = 1'b1; cmd.kind = KIND_ACK; cmd.emit_src = SRC_ACK;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// finished-entry mark happens with the update emit of a tick
		if (state_q == ST_EMIT && !stat.out_busy && stat.cmd == CMD_TICK && stat.need_div == 1'b0
			&& !stat.waiting)
			cmd.mark_fin = 1'b1;
	end
endmodule

[hw/rtl/eased_animation_timer_table_core.sv]
// Top level: eased ramp timer table, controller plus datapath.
//
// Usage:
//   Input channel (valid/ready) carries one request: command, time_ms,
//   duration_ms, delay_ms, curve, anim_id. Output channel (out_valid /
//   out_ready) carries result items; the one with last = 1 closes a request.
//   One request is worked at a time; ready is high only while idle and the
//   output register is free.
// Sequence:
//   play: dispatch, then its acknowledge; zero-duration play first emits
//   an update and a done. cancel: search, then compaction of the entries.
//   tick: per started entry the serial divider (32 steps) while it still
//   runs, then ST_EASE1 and ST_EASE2; then a pass to list completions and
//   a pass to compact. The divider dominates the run time of a full tick.
// Reset: table empties, next id returns to 1, no result pending.
// Stall: a held output register freezes the controller before each emit;
//   no result is lost or repeated.
module eased_animation_timer_table_core #(
	parameter int MAX_ANIMATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  command,
	input  logic [31:0] time_ms,
	input  logic [15:0] duration_ms,
	input  logic [15:0] delay_ms,
	input  logic [1:0]  curve,
	input  logic [15:0] anim_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [15:0] out_id,
	output logic [16:0] eased_value,
	output logic        completed_normally,
	output logic        any_active,
	output logic        table_full,
	output logic        last
);
	import eatt_pkg::*;

	eatt_cmd_t  cmd;
	eatt_stat_t stat;

	eatt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.stat(stat), .cmd(cmd)
	);

	eatt_datapath #(.MAX_ANIMATIONS(MAX_ANIMATIONS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.command(command), .time_ms(time_ms), .duration_ms(duration_ms),
		.delay_ms(delay_ms), .curve(curve), .anim_id(anim_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .out_id(out_id), .eased_value(eased_value),
		.completed_normally(completed_normally), .any_active(any_active),
		.table_full(table_full), .last(last)
	);
endmodule
